// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files that carry checks.
// Depends on a clk and an arst_n signal in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, off during reset
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication in the next cycle, off during reset
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/sminv_pkg.sv
// Types, widths and the restoring divide step of the small matrix inverse.
// No dependencies; used by small_matrix_inverse.
package sminv_pkg;

	localparam int EW    = 16;          // input element width
	localparam int RW    = 32;          // result element width
	localparam int NEL   = 9;           // matrix elements
	localparam int NW    = 56;          // numerator magnitude, |cofactor| << 24
	localparam int DW    = 48;          // determinant magnitude
	localparam int CW    = DW + RW;     // compare width of a shifted divisor
	localparam int NSTEP = RW;          // quotient bits, one per stage

	typedef struct packed {
		logic [NW-1:0] rem;
		logic [RW-1:0] quo;
		logic          neg;
		logic          ovf;
	} lane_t;

	typedef struct packed {
		logic              sing;
		logic              sz;
		logic [DW-1:0]     dmag;
		lane_t [NEL-1:0]   lane;
	} divst_t;

	// One restoring step on all lanes: quotient bit k
	function automatic divst_t div_step(divst_t st, int k);
		divst_t        nx;
		logic [CW-1:0] dsh;
		logic [CW-1:0] rx;
		nx  = st;
		dsh = CW'(st.dmag) << k;
		for (int l = 0; l < NEL; l++) begin
			rx = CW'(st.lane[l].rem);
			if (rx >= dsh) begin
				nx.lane[l].rem        = NW'(rx - dsh);
				nx.lane[l].quo[5'(k)] = 1'b1;
			end
		end
		return nx;
	endfunction

endpackage

// File: rtl/small_matrix_inverse.sv
// Top level of the 2x2 / 3x3 matrix inverse (adjugate over determinant).
// Depends on sminv_pkg and assert_macros.svh.

// One matrix enters every cycle unless the output stalls. The path is
// products, cofactors, determinant terms, determinant sum, magnitudes, an
// overflow check, then a 32-stage restoring divider that settles one quotient
// bit per stage on all nine lanes, and an output register that applies sign
// and saturation. A stall on the output holds the whole pipeline; s_tready is
// high whenever the output register is empty or being taken.
`include "assert_macros.svh"

module small_matrix_inverse (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each, signed Q8.8)
	input  logic [143:0] s_tdata,
	// size_is_three
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// r00, r01, r02, r10, r11, r12, r20, r21, r22 (32 bits each, signed Q16.16)
	output logic [287:0] m_tdata,
	// singular
	output logic [0:0]   m_tuser
);

	localparam int EW  = sminv_pkg::EW;
	localparam int RW  = sminv_pkg::RW;
	localparam int NEL = sminv_pkg::NEL;
	localparam int NST = 6 + sminv_pkg::NSTEP + 1;

	logic           adv;
	logic [NST-1:0] vld_q;

	// stage 1: element products
	logic signed [2*EW-1:0] pp_s1 [NEL];
	logic signed [2*EW-1:0] pn_s1 [NEL];
	logic signed [EW-1:0]   a_s1, b_s1, c_s1, d_s1, e_s1;
	logic                   sz_s1;
	// stage 2: cofactors
	logic signed [2*EW:0]   cof_s2 [NEL];
	logic signed [EW-1:0]   a_s2, b_s2, c_s2, d_s2, e_s2;
	logic                   sz_s2;
	// stage 3: determinant terms
	logic signed [2*EW:0]   cof_s3 [NEL];
	logic signed [3*EW:0]   t_s3 [3];
	logic signed [EW-1:0]   a_s3, b_s3, d_s3, e_s3;
	logic                   sz_s3;
	// stage 4: determinant and numerators
	logic signed [3*EW+1:0] det_s4;
	logic signed [2*EW:0]   num_s4 [NEL];
	logic                   sz_s4;
	// stage 5: magnitudes, then divider stages
	sminv_pkg::divst_t      ab_s5;
	sminv_pkg::divst_t      div_s [sminv_pkg::NSTEP+1];
	sminv_pkg::divst_t      div_n [1:sminv_pkg::NSTEP];
	// output register
	logic [287:0]           dat_q;
	logic                   sing_q;
	logic                   sz_q;

	logic signed [EW-1:0] m [NEL];
	always_comb begin
		for (int k = 0; k < NEL; k++) m[k] = s_tdata[k*EW +: EW];
	end

	assign adv      = !vld_q[NST-1] || m_tready;
	assign s_tready = adv;

	// advance valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], s_tvalid};
		end
	end

	// stages 1 to 4
	always_ff @(posedge clk) begin
		if (adv) begin
			// positive and negative product of each cofactor
			pp_s1[0] <= m[4] * m[8];  pn_s1[0] <= m[5] * m[7];
			pp_s1[1] <= m[2] * m[7];  pn_s1[1] <= m[1] * m[8];
			pp_s1[2] <= m[1] * m[5];  pn_s1[2] <= m[2] * m[4];
			pp_s1[3] <= m[5] * m[6];  pn_s1[3] <= m[3] * m[8];
			pp_s1[4] <= m[0] * m[8];  pn_s1[4] <= m[2] * m[6];
			pp_s1[5] <= m[2] * m[3];  pn_s1[5] <= m[0] * m[5];
			pp_s1[6] <= m[3] * m[7];  pn_s1[6] <= m[4] * m[6];
			pp_s1[7] <= m[1] * m[6];  pn_s1[7] <= m[0] * m[7];
			pp_s1[8] <= m[0] * m[4];  pn_s1[8] <= m[1] * m[3];
			a_s1 <= m[0]; b_s1 <= m[1]; c_s1 <= m[2]; d_s1 <= m[3]; e_s1 <= m[4];
			sz_s1 <= s_tuser[0];

			for (int k = 0; k < NEL; k++) cof_s2[k] <= pp_s1[k] - pn_s1[k];
			a_s2 <= a_s1; b_s2 <= b_s1; c_s2 <= c_s1; d_s2 <= d_s1; e_s2 <= e_s1;
			sz_s2 <= sz_s1;

			cof_s3 <= cof_s2;
			t_s3[0] <= a_s2 * cof_s2[0];
			t_s3[1] <= b_s2 * cof_s2[3];
			t_s3[2] <= c_s2 * cof_s2[6];
			a_s3 <= a_s2; b_s3 <= b_s2; d_s3 <= d_s2; e_s3 <= e_s2;
			sz_s3 <= sz_s2;

			// pick determinant and numerators by size
			if (sz_s3) begin
				det_s4 <= t_s3[0] + t_s3[1] + t_s3[2];
				num_s4 <= cof_s3;
			end else begin
				det_s4 <= (3*EW+2)'(cof_s3[8]);
				num_s4[0] <= (2*EW+1)'(e_s3);
				num_s4[1] <= -(2*EW+1)'(b_s3);
				num_s4[2] <= '0;
				num_s4[3] <= -(2*EW+1)'(d_s3);
				num_s4[4] <= (2*EW+1)'(a_s3);
				for (int k = 5; k < NEL; k++) num_s4[k] <= '0;
			end
			sz_s4 <= sz_s3;
		end
	end

	// stage 5: magnitudes and result signs
	logic signed [3*EW+1:0] dabs;
	logic signed [2*EW:0]   nabs [NEL];
	always_comb begin
		dabs = det_s4[3*EW+1] ? -det_s4 : det_s4;
		for (int k = 0; k < NEL; k++) nabs[k] = num_s4[k][2*EW] ? -num_s4[k] : num_s4[k];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ab_s5.sing <= (det_s4 == '0);
			ab_s5.sz   <= sz_s4;
			ab_s5.dmag <= dabs[sminv_pkg::DW-1:0];
			for (int k = 0; k < NEL; k++) begin
				ab_s5.lane[k].rem <= {nabs[k][RW-1:0], 24'd0};
				ab_s5.lane[k].quo <= '0;
				ab_s5.lane[k].neg <= num_s4[k][2*EW] ^ det_s4[3*EW+1];
				ab_s5.lane[k].ovf <= 1'b0;
			end
		end
	end

	// overflow check: quotient would reach 2^32
	sminv_pkg::divst_t ov_n;
	logic [sminv_pkg::CW-1:0] dtop;
	always_comb begin
		ov_n = ab_s5;
		dtop = {ab_s5.dmag, {RW{1'b0}}};
		for (int k = 0; k < NEL; k++) begin
			ov_n.lane[k].ovf = (sminv_pkg::CW'(ab_s5.lane[k].rem) >= dtop);
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar j = 0; j < sminv_pkg::NSTEP; j++) begin : g_div
		assign div_n[j+1] = sminv_pkg::div_step(div_s[j], sminv_pkg::NSTEP - 1 - j);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0] <= ov_n;
			for (int j = 1; j <= sminv_pkg::NSTEP; j++) div_s[j] <= div_n[j];
		end
	end

	// sign, saturation and singular zeroing
	function automatic logic [RW-1:0] fix_out(sminv_pkg::lane_t ln, logic sing);
		logic [RW-1:0] r;
		if (sing) begin
			r = '0;
		end else if (!ln.neg) begin
			r = (ln.ovf || ln.quo[RW-1]) ? {1'b0, {(RW-1){1'b1}}} : ln.quo;
		end else begin
			r = (ln.ovf || (ln.quo > {1'b1, {(RW-1){1'b0}}})) ?
				{1'b1, {(RW-1){1'b0}}} : -ln.quo;
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NEL; k++) begin
				dat_q[k*RW +: RW] <= fix_out(div_s[sminv_pkg::NSTEP].lane[k],
					div_s[sminv_pkg::NSTEP].sing);
			end
			sing_q <= div_s[sminv_pkg::NSTEP].sing;
			sz_q   <= div_s[sminv_pkg::NSTEP].sz;
		end
	end

	assign m_tvalid   = vld_q[NST-1];
	assign m_tdata    = dat_q;
	assign m_tuser[0] = sing_q;

	// checks
	`ASSERT_SAME(a_sing_zero, m_tvalid && m_tuser[0], m_tdata == '0)
	`ASSERT_SAME(a_two_zero, m_tvalid && !sz_q,
		m_tdata[287:160] == '0 && m_tdata[95:64] == '0)
	`ASSERT_NEXT(a_hold_vld, !adv, vld_q == $past(vld_q))

endmodule

// File: tb/sv/tb_small_matrix_inverse.sv
// Testbench for small_matrix_inverse: 2x2 and 3x3 inverses in Q16.16.
// Depends on the small_matrix_inverse RTL; self-checking with its own predictor.
`timescale 1ns / 1ps

module tb_small_matrix_inverse;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [143:0] s_tdata;
	logic [0:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [287:0] m_tdata;
	logic [0:0]   m_tuser;

	logic [0:0]   exp_sing [$];
	logic [287:0] exp_data [$];
	int           fail_cnt;
	bit           idle_en;

	small_matrix_inverse dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Quotient of cofactor << 24 over determinant, truncated and saturated
	function automatic logic [31:0] fix_quot(longint cof, longint det);
		longint q;
		q = (cof * 64'sd16777216) / det;
		if (q > 64'sd2147483647) q = 64'sd2147483647;
		if (q < -64'sd2147483648) q = -64'sd2147483648;
		return q[31:0];
	endfunction

	// Predict the inverse of one matrix
	task automatic predict_inverse(input logic sz, input logic [143:0] m);
		longint       e [9];
		longint       cof [9];
		longint       det;
		logic [287:0] res;
		res = '0;
		for (int k = 0; k < 9; k++) e[k] = longint'($signed(m[16*k +: 16]));
		if (sz) begin
			cof[0] = e[4]*e[8] - e[5]*e[7];
			cof[1] = e[2]*e[7] - e[1]*e[8];
			cof[2] = e[1]*e[5] - e[2]*e[4];
			cof[3] = e[5]*e[6] - e[3]*e[8];
			cof[4] = e[0]*e[8] - e[2]*e[6];
			cof[5] = e[2]*e[3] - e[0]*e[5];
			cof[6] = e[3]*e[7] - e[4]*e[6];
			cof[7] = e[1]*e[6] - e[0]*e[7];
			cof[8] = e[0]*e[4] - e[1]*e[3];
			det = e[0]*cof[0] + e[1]*cof[3] + e[2]*cof[6];
			if (det != 0)
				for (int k = 0; k < 9; k++) res[32*k +: 32] = fix_quot(cof[k], det);
		end else begin
			det = e[0]*e[4] - e[1]*e[3];
			if (det != 0) begin
				res[0 +: 32]  = fix_quot(e[4], det);
				res[32 +: 32] = fix_quot(-e[1], det);
				res[96 +: 32] = fix_quot(-e[3], det);
				res[128 +: 32] = fix_quot(e[0], det);
			end
		end
		exp_sing.push_back(det == 0);
		exp_data.push_back(res);
	endtask

	// Send one matrix and hold it until the transaction completes
	task automatic send_matrix(input logic sz, input logic [143:0] m);
		while (idle_en && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= m;
		s_tuser  <= sz;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_inverse(sz, m);
		@(negedge clk);
	endtask

	function automatic logic [143:0] rand_matrix(int mode);
		logic [143:0] m;
		for (int k = 0; k < 9; k++)
			case (mode)
				0: m[16*k +: 16] = 16'($urandom);
				1: m[16*k +: 16] = 16'($signed($urandom_range(1024)) - 512);
				default: m[16*k +: 16] = 16'($signed($urandom_range(8)) - 4);
			endcase
		return m;
	endfunction

	// Check each result against the oldest prediction
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (exp_data.size() == 0) begin
				$error("unexpected result");
				fail_cnt++;
			end else begin
				logic [0:0]   es;
				logic [287:0] ed;
				es = exp_sing.pop_front();
				ed = exp_data.pop_front();
				if (m_tuser !== es) begin
					$error("singular: expected %0d actual %0d", es, m_tuser);
					fail_cnt++;
				end
				for (int k = 0; k < 9; k++)
					if (m_tdata[32*k +: 32] !== ed[32*k +: 32]) begin
						$error("r%0d%0d: expected %0d actual %0d", k / 3, k % 3,
							$signed(ed[32*k +: 32]), $signed(m_tdata[32*k +: 32]));
						fail_cnt++;
					end
			end
		end
	end

	// Output stall
	always @(negedge clk) begin
		m_tready <= !(idle_en && $urandom_range(99) < 6);
	end

	task automatic test_directed;
		logic [143:0] idm;
		idm = '0;
		idm[0 +: 16] = 16'h0100; idm[64 +: 16] = 16'h0100; idm[128 +: 16] = 16'h0100;
		send_matrix(1'b1, idm);
		send_matrix(1'b0, idm);
		send_matrix(1'b1, '0);
		send_matrix(1'b0, '0);
		send_matrix(1'b1, {9{16'h7fff}});
		send_matrix(1'b1, {9{16'h8000}});
		send_matrix(1'b0, {16'hffff, 16'h1234, 16'hffff, 16'h8000, 16'h7fff,
			16'h0000, 16'h0000, 16'h0001, 16'h0001});
		// tiny determinant gives a large inverse
		idm = '0;
		idm[0 +: 16] = 16'h0001; idm[64 +: 16] = 16'h0001; idm[128 +: 16] = 16'h0001;
		send_matrix(1'b1, idm);
		send_matrix(1'b0, idm);
		idm[16 +: 16] = 16'h8000; idm[48 +: 16] = 16'h7fff;
		send_matrix(1'b0, idm);
		send_matrix(1'b1, idm);
		send_matrix(1'b1, {16'h7fff, 16'h8000, 16'h0001, 16'h8000, 16'h7fff,
			16'hffff, 16'h0001, 16'hffff, 16'h7fff});
		send_matrix(1'b0, {144{1'b1}});
	endtask

	task automatic test_random(input int n);
		for (int i = 0; i < n; i++)
			send_matrix(1'($urandom_range(1)), rand_matrix(int'($urandom_range(2))));
	endtask

	task automatic test_drain_pause;
		s_tvalid <= 1'b0;
		while (exp_data.size() != 0) @(negedge clk);
		test_random(20);
	endtask

	task automatic test_no_idle;
		idle_en = 1'b0;
		test_random(150);
		idle_en = 1'b1;
	endtask

	initial begin
		fail_cnt = 0;
		idle_en  = 1'b1;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		m_tready = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(400);
		test_drain_pause();
		test_no_idle();
		test_random(370);
		s_tvalid <= 1'b0;
		while (exp_data.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (fail_cnt == 0 && exp_data.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Timeout
	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
